>>> rtl/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and defaults of the min-priority message queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mpq_pkg;

	localparam int CAPACITY_DEF   = 64;
	localparam int NAME_BYTES_DEF = 10;

	localparam int PRIO_W = 31;
	localparam int NAME_W = 64;
	localparam int TAIL_W = 16;

	// Request codes on the input channel
	localparam logic ACT_PUT = 1'b0;
	localparam logic ACT_GET = 1'b1;

	// One stored message
	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [NAME_W-1:0] name;
		logic [TAIL_W-1:0] tail;
	} entry_t;

	// Port enables of the entry store
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

endpackage

`default_nettype wire

>>> rtl/mpq_store.sv
// ----------------------------------------------------------------------------
// mpq_store
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mpq_store #(
	parameter int CAPACITY = mpq_pkg::CAPACITY_DEF
) (
	input  wire logic                        clk,
	input  wire mpq_pkg::mem_ctl_t           mem_ctl,
	input  wire logic [$clog2(CAPACITY)-1:0] waddr,
	input  wire mpq_pkg::entry_t             wdata,
	input  wire logic [$clog2(CAPACITY)-1:0] raddr,
	output mpq_pkg::entry_t                  rdata
);
	import mpq_pkg::*;

	entry_t mem_q [CAPACITY];
	entry_t rdata_q;

	// Write one entry
	always_ff @(posedge clk) begin
		if (mem_ctl.wr_en) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read one entry, registered
	always_ff @(posedge clk) begin
		if (mem_ctl.rd_en) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> rtl/mpq_ctrl.sv
// ----------------------------------------------------------------------------
// mpq_ctrl
// Sequencer of the queue: insertion walk for put, head removal and shift for
// get, one entry through the shared priority comparator each cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mpq_ctrl #(
	parameter int CAPACITY = mpq_pkg::CAPACITY_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// request channel
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        action,
	input  wire mpq_pkg::entry_t             new_entry,
	// entry store
	output mpq_pkg::mem_ctl_t                mem_ctl,
	output logic [$clog2(CAPACITY)-1:0]      waddr,
	output mpq_pkg::entry_t                  wdata,
	output logic [$clog2(CAPACITY)-1:0]      raddr,
	input  wire mpq_pkg::entry_t             rdata,
	// result channel
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             queue_empty,
	output mpq_pkg::entry_t                  out_entry
);
	import mpq_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_PCMP   = 5'b00010,
		S_PWR    = 5'b00100,
		S_GHEAD  = 5'b01000,
		S_GSHIFT = 5'b10000
	} state_t;

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] idx_dec;
	entry_t        new_q, new_d;
	logic          out_valid_q, out_valid_d;
	logic          out_empty_q, out_empty_d;
	entry_t        out_entry_q, out_entry_d;
	logic          accept;
	logic          greater;

	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;

	// Shared comparator: stored entry goes behind the new one only when larger
	assign greater = rdata.prio > new_q.prio;
	assign idx_dec = idx_q - 1'b1;

	// Sequencer
	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		idx_d       = idx_q;
		new_d       = new_q;
		out_valid_d = out_valid_q && out_stall;
		out_empty_d = out_empty_q;
		out_entry_d = out_entry_q;
		mem_ctl     = '0;
		waddr       = '0;
		wdata       = rdata;
		raddr       = '0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (action == ACT_PUT) begin
						new_d = new_entry;
						if (cnt_q == '0) begin
							mem_ctl.wr_en = 1'b1;
							wdata         = new_entry;
							cnt_d         = CW'(1);
						end else begin
							// walk back from the tail; a full queue starts past the end
							mem_ctl.rd_en = 1'b1;
							raddr         = AW'(cnt_q - 1'b1);
							idx_d         = cnt_q;
							state_d       = S_PCMP;
						end
					end else if (cnt_q == '0) begin
						out_valid_d = 1'b1;
						out_empty_d = 1'b1;
						out_entry_d = '0;
					end else begin
						mem_ctl.rd_en = 1'b1;
						raddr         = '0;
						state_d       = S_GHEAD;
					end
				end
			end
			S_PCMP: begin
				if (greater) begin
					// move the larger entry one slot back, drop it past the end
					mem_ctl.wr_en = idx_q < CAP_C;
					waddr         = AW'(idx_q);
					wdata         = rdata;
					idx_d         = idx_dec;
					if (idx_dec == '0) begin
						state_d = S_PWR;
					end else begin
						mem_ctl.rd_en = 1'b1;
						raddr         = AW'(idx_q - 2'd2);
					end
				end else begin
					// place the new entry; past the end it is dropped
					mem_ctl.wr_en = idx_q < CAP_C;
					waddr         = AW'(idx_q);
					wdata         = new_q;
					if (cnt_q < CAP_C) begin
						cnt_d = cnt_q + 1'b1;
					end
					state_d = S_IDLE;
				end
			end
			S_PWR: begin
				mem_ctl.wr_en = 1'b1;
				waddr         = '0;
				wdata         = new_q;
				if (cnt_q < CAP_C) begin
					cnt_d = cnt_q + 1'b1;
				end
				state_d = S_IDLE;
			end
			S_GHEAD: begin
				out_valid_d = 1'b1;
				out_empty_d = 1'b0;
				out_entry_d = rdata;
				if (cnt_q == CW'(1)) begin
					cnt_d   = '0;
					state_d = S_IDLE;
				end else begin
					mem_ctl.rd_en = 1'b1;
					raddr         = AW'(1);
					idx_d         = CW'(1);
					state_d       = S_GSHIFT;
				end
			end
			S_GSHIFT: begin
				// advance each entry one slot toward the head
				mem_ctl.wr_en = 1'b1;
				waddr         = AW'(idx_dec);
				wdata         = rdata;
				if ((idx_q + 1'b1) < cnt_q) begin
					mem_ctl.rd_en = 1'b1;
					raddr         = AW'(idx_q + 1'b1);
					idx_d         = idx_q + 1'b1;
				end else begin
					cnt_d   = cnt_q - 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			idx_q       <= idx_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Payload holding registers
	always_ff @(posedge clk) begin
		new_q       <= new_d;
		out_empty_q <= out_empty_d;
		out_entry_q <= out_entry_d;
	end

	assign out_valid   = out_valid_q;
	assign queue_empty = out_empty_q;
	assign out_entry   = out_entry_q;

endmodule

`default_nettype wire

>>> rtl/min_priority_message_queue.sv
// Put: on an empty queue the entry is written on acceptance; otherwise the block
//   moves each larger entry one slot back from the tail, then writes the new one.
// Get: an empty queue returns a beat flagged empty with no busy period; otherwise
//   the head is returned and the block stays busy while the rest moves up a slot.
// The entry store has one write and one read port, so one entry moves a cycle.
// Reset clears the control state and count; stored entries stay undefined.
// ----------------------------------------------------------------------------
// min_priority_message_queue
// Sorted message queue, smallest priority served first, ties first in first out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module min_priority_message_queue #(
	parameter int CAPACITY   = mpq_pkg::CAPACITY_DEF,
	parameter int NAME_BYTES = mpq_pkg::NAME_BYTES_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       action,
	input  wire logic [mpq_pkg::PRIO_W-1:0] priority_req,
	input  wire logic [mpq_pkg::NAME_W-1:0] name_low,
	input  wire logic [mpq_pkg::TAIL_W-1:0] name_high,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic                            queue_empty,
	output logic [mpq_pkg::PRIO_W-1:0]      out_priority,
	output logic [mpq_pkg::NAME_W-1:0]      out_name_low,
	output logic [mpq_pkg::TAIL_W-1:0]      out_name_high
);
	import mpq_pkg::*;

	localparam int AW = $clog2(CAPACITY);

	entry_t          new_entry;
	entry_t          out_entry;
	entry_t          wdata;
	entry_t          rdata;
	mem_ctl_t        mem_ctl;
	logic [AW-1:0]   waddr;
	logic [AW-1:0]   raddr;

	// Zero name bytes beyond the name length
	always_comb begin
		new_entry.prio = priority_req;
		for (int b = 0; b < 8; b++) begin
			new_entry.name[8*b +: 8] = (b < NAME_BYTES) ? name_low[8*b +: 8] : 8'h00;
		end
		for (int b = 0; b < 2; b++) begin
			new_entry.tail[8*b +: 8] = (b + 8 < NAME_BYTES) ? name_high[8*b +: 8] : 8'h00;
		end
	end

	mpq_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.new_entry  (new_entry),
		.mem_ctl    (mem_ctl),
		.waddr      (waddr),
		.wdata      (wdata),
		.raddr      (raddr),
		.rdata      (rdata),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.queue_empty(queue_empty),
		.out_entry  (out_entry)
	);

	mpq_store #(
		.CAPACITY(CAPACITY)
	) u_store (
		.clk    (clk),
		.mem_ctl(mem_ctl),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr  (raddr),
		.rdata  (rdata)
	);

	assign out_priority  = out_entry.prio;
	assign out_name_low  = out_entry.name;
	assign out_name_high = out_entry.tail;

	// A held result beat blocks new requests
	a_hold_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("request taken while a result beat is held");

	// An empty result carries zero fields
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && queue_empty |->
			out_priority == '0 && out_name_low == '0 && out_name_high == '0)
		else $error("empty result with nonzero fields");

	// A get either answers at once or keeps the block busy
	a_get_progress: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && action == ACT_GET |=> out_valid || in_stall)
		else $error("get accepted with no result and no busy period");

endmodule

`default_nettype wire
